FILE: rtl/core/yds_pkg.sv
// Shared types and constants for the YUV downscale to RGB block.
package yds_pkg;

    // Fixed field widths of the pixel channels and configuration registers
    localparam int SAMPLE_W = 8;
    localparam int POS_W    = 12;
    localparam int CFG_W    = 13;

    // Configuration port geometry: five 32-bit registers at 4*i
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Register indexes
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_OUT_WIDTH  = 3'd2;
    localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_CHROMA_EN  = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 13'd480;
    localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 13'd256;
    localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 13'd192;

    // BT.601 full-swing coefficients in millionths, rounded to the fraction at elaboration
    localparam longint unsigned COEF_R_MICRO  = 64'd1402000;
    localparam longint unsigned COEF_GB_MICRO = 64'd344136;
    localparam longint unsigned COEF_GR_MICRO = 64'd714136;
    localparam longint unsigned COEF_B_MICRO  = 64'd1772000;
    localparam longint unsigned MICRO_ONE     = 64'd1000000;
    localparam longint unsigned MICRO_HALF    = 64'd500000;

    // Chroma offset
    localparam logic signed [SAMPLE_W:0] CHROMA_MID = 9'sd128;

    // Position accumulator rebuild sequence after reset or a register write
    typedef enum logic [2:0] {
        RC_IDLE,
        RC_DIMS,
        RC_COL_S,
        RC_COL_T,
        RC_ROW_S,
        RC_ROW_T
    } t_recalc;

endpackage

FILE: rtl/core/yds_pix_if.sv
// Source pixel channel: luma, chroma of the 2x2 site and frame start marker.
interface yds_pix_if;
    logic                          valid;
    logic                          ready;
    logic [yds_pkg::SAMPLE_W-1:0]  luma;
    logic [yds_pkg::SAMPLE_W-1:0]  cb_sample;
    logic [yds_pkg::SAMPLE_W-1:0]  cr_sample;
    logic                          frame_start;

    modport source (output valid, luma, cb_sample, cr_sample, frame_start, input ready);
    modport sink   (input valid, luma, cb_sample, cr_sample, frame_start, output ready);
endinterface

FILE: rtl/core/yds_rgb_if.sv
// Result pixel channel: gray, RGB and output position.
interface yds_rgb_if;
    logic                          valid;
    logic                          ready;
    logic [yds_pkg::SAMPLE_W-1:0]  gray;
    logic [yds_pkg::SAMPLE_W-1:0]  red;
    logic [yds_pkg::SAMPLE_W-1:0]  green;
    logic [yds_pkg::SAMPLE_W-1:0]  blue;
    logic [yds_pkg::POS_W-1:0]     out_x;
    logic [yds_pkg::POS_W-1:0]     out_y;
    logic                          last;

    modport source (output valid, gray, red, green, blue, out_x, out_y, last, input ready);
    modport sink   (input valid, gray, red, green, blue, out_x, out_y, last, output ready);
endinterface

FILE: rtl/core/yuv_downscale_to_rgb_unit.sv
// Nearest-neighbor downscaler with BT.601 YCbCr to RGB conversion.
//
// Source pixels enter on i_pix in raster order, one word per cycle while
// i_pix.ready is high; frame_start on a word restarts the position counters
// at source pixel (0,0). Each source pixel that lands on an output grid
// position leaves on o_rgb as one word (gray, red, green, blue, out_x, out_y,
// last); other pixels leave nothing. Column and row selection compares running
// products 2*OW*col against (2*ox+1)*W, stepped by additions, so a new pixel is
// taken every cycle that i_pix.ready is high. From acceptance to o_rgb.valid a
// word passes two registers: the first holds the selected pixel and position,
// the second the converted colors. Throughput is 1 word per cycle while the
// input is not stalled; a stalled receiver backs up through the two registers,
// and i_pix.ready drops once both are full. Reset loads the register defaults
// and clears the counters. After reset and after every register write
// i_pix.ready stays low while RC_DIMS latches the effective sizes, then one
// shared multiplier rebuilds the four position products in turn. Registers are
// written over APB with pready tied high; reads return the stored values.
module yuv_downscale_to_rgb_unit #(
    parameter int MAX_DIM        = 4096,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [yds_pkg::APB_AW-1:0]  paddr,
    input  logic [yds_pkg::APB_DW-1:0]  pwdata,
    output logic [yds_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    yds_pix_if.sink                     i_pix,
    yds_rgb_if.source                   o_rgb
);

    localparam int DW  = $clog2(MAX_DIM) + 1;     // holds 0..MAX_DIM
    localparam int AW  = 2 * DW + 1;              // position products
    localparam int F   = COEF_FRAC_BITS;
    localparam int KW  = F + 2;                   // coefficient magnitude bits
    localparam int SW  = F + 12;                  // signed color sum
    localparam int SMW = yds_pkg::SAMPLE_W;

    localparam longint unsigned KR_U =
        ((yds_pkg::COEF_R_MICRO << F) + yds_pkg::MICRO_HALF) / yds_pkg::MICRO_ONE;
    localparam longint unsigned KGB_U =
        ((yds_pkg::COEF_GB_MICRO << F) + yds_pkg::MICRO_HALF) / yds_pkg::MICRO_ONE;
    localparam longint unsigned KGR_U =
        ((yds_pkg::COEF_GR_MICRO << F) + yds_pkg::MICRO_HALF) / yds_pkg::MICRO_ONE;
    localparam longint unsigned KB_U =
        ((yds_pkg::COEF_B_MICRO << F) + yds_pkg::MICRO_HALF) / yds_pkg::MICRO_ONE;

    localparam logic signed [KW:0] K_R  = (KW+1)'(KR_U);
    localparam logic signed [KW:0] K_GB = (KW+1)'(KGB_U);
    localparam logic signed [KW:0] K_GR = (KW+1)'(KGR_U);
    localparam logic signed [KW:0] K_B  = (KW+1)'(KB_U);
    localparam logic signed [SW-1:0] CH_TOP = SW'(255) <<< F;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [yds_pkg::CFG_W-1:0] r_cfg_src_w, r_cfg_src_h, r_cfg_out_w, r_cfg_out_h;
    logic                      r_cfg_chroma;
    logic                      cfg_wr;
    logic [2:0]                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[yds_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Store register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_src_w  <= yds_pkg::RST_SRC_WIDTH;
            r_cfg_src_h  <= yds_pkg::RST_SRC_HEIGHT;
            r_cfg_out_w  <= yds_pkg::RST_OUT_WIDTH;
            r_cfg_out_h  <= yds_pkg::RST_OUT_HEIGHT;
            r_cfg_chroma <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                yds_pkg::REG_SRC_WIDTH:  r_cfg_src_w  <= pwdata[yds_pkg::CFG_W-1:0];
                yds_pkg::REG_SRC_HEIGHT: r_cfg_src_h  <= pwdata[yds_pkg::CFG_W-1:0];
                yds_pkg::REG_OUT_WIDTH:  r_cfg_out_w  <= pwdata[yds_pkg::CFG_W-1:0];
                yds_pkg::REG_OUT_HEIGHT: r_cfg_out_h  <= pwdata[yds_pkg::CFG_W-1:0];
                yds_pkg::REG_CHROMA_EN:  r_cfg_chroma <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Return stored register values
    always_comb begin
        case (cfg_idx)
            yds_pkg::REG_SRC_WIDTH:  prdata = yds_pkg::APB_DW'(r_cfg_src_w);
            yds_pkg::REG_SRC_HEIGHT: prdata = yds_pkg::APB_DW'(r_cfg_src_h);
            yds_pkg::REG_OUT_WIDTH:  prdata = yds_pkg::APB_DW'(r_cfg_out_w);
            yds_pkg::REG_OUT_HEIGHT: prdata = yds_pkg::APB_DW'(r_cfg_out_h);
            yds_pkg::REG_CHROMA_EN:  prdata = yds_pkg::APB_DW'(r_cfg_chroma);
            default:                 prdata = '0;
        endcase
    end

    // Zero counts as one, oversize saturates to the maximum
    function automatic logic [DW-1:0] eff_dim(input logic [yds_pkg::CFG_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0)
            return DW'(1);
        else if (v32 > 32'(MAX_DIM))
            return DW'(MAX_DIM);
        else
            return DW'(v32);
    endfunction

    // ------------------------------------------------------------------
    // Effective sizes and accumulator rebuild sequencer
    // ------------------------------------------------------------------
    yds_pkg::t_recalc r_rc, n_rc;
    logic [DW-1:0] r_w, r_h, r_ow, r_oh;
    logic [DW-1:0] n_w, n_h, n_ow, n_oh;
    logic [DW-1:0] eff_w, eff_h, eff_ow, eff_oh;

    // Position state
    logic [DW-1:0] r_src_col, r_src_row, r_out_col, r_out_row;
    logic [DW-1:0] n_src_col, n_src_row, n_out_col, n_out_row;
    logic [AW-1:0] r_cs, r_ct, r_rs, r_rt;        // 2*OW*col, (2*ox+1)*W, rows alike
    logic [AW-1:0] n_cs, n_ct, n_rs, n_rt;

    logic [DW:0]   mul_a;
    logic [DW-1:0] mul_b;
    logic [AW-1:0] mul_p;

    assign eff_w  = eff_dim(r_cfg_src_w);
    assign eff_h  = eff_dim(r_cfg_src_h);
    assign eff_ow = (eff_dim(r_cfg_out_w) > eff_w) ? eff_w : eff_dim(r_cfg_out_w);
    assign eff_oh = (eff_dim(r_cfg_out_h) > eff_h) ? eff_h : eff_dim(r_cfg_out_h);

    // Step through the rebuild, restart on any register write
    always_comb begin
        n_rc = r_rc;
        case (r_rc)
            yds_pkg::RC_IDLE:  n_rc = yds_pkg::RC_IDLE;
            yds_pkg::RC_DIMS:  n_rc = yds_pkg::RC_COL_S;
            yds_pkg::RC_COL_S: n_rc = yds_pkg::RC_COL_T;
            yds_pkg::RC_COL_T: n_rc = yds_pkg::RC_ROW_S;
            yds_pkg::RC_ROW_S: n_rc = yds_pkg::RC_ROW_T;
            yds_pkg::RC_ROW_T: n_rc = yds_pkg::RC_IDLE;
            default:           n_rc = yds_pkg::RC_IDLE;
        endcase
        if (cfg_wr)
            n_rc = yds_pkg::RC_DIMS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_rc <= yds_pkg::RC_DIMS;
        else
            r_rc <= n_rc;
    end

    // Shared multiplier for the rebuild
    always_comb begin
        case (r_rc)
            yds_pkg::RC_COL_S: begin
                mul_a = {r_ow, 1'b0};
                mul_b = r_src_col;
            end
            yds_pkg::RC_COL_T: begin
                mul_a = {r_out_col, 1'b1};
                mul_b = r_w;
            end
            yds_pkg::RC_ROW_S: begin
                mul_a = {r_oh, 1'b0};
                mul_b = r_src_row;
            end
            yds_pkg::RC_ROW_T: begin
                mul_a = {r_out_row, 1'b1};
                mul_b = r_h;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = AW'(mul_a) * AW'(mul_b);
    end

    // ------------------------------------------------------------------
    // Pixel selection at the input
    // ------------------------------------------------------------------
    logic          pix_acc, s1_adv, out_free;
    logic          r_s1_valid;
    logic          clr, row_hit, emit, pos_last;
    logic [DW-1:0] c_col, c_row, c_ox, c_oy;
    logic [AW-1:0] c_cs, c_ct, c_rs, c_rt;
    logic [AW-1:0] w_a, h_a, ow2_a, oh2_a;
    logic [DW:0]   col_inc, row_inc;

    assign out_free    = !o_rgb.valid || o_rgb.ready;
    assign s1_adv      = out_free;
    assign i_pix.ready = (r_rc == yds_pkg::RC_IDLE) && (!r_s1_valid || s1_adv);
    assign pix_acc     = i_pix.valid && i_pix.ready;

    assign w_a   = AW'(r_w);
    assign h_a   = AW'(r_h);
    assign ow2_a = AW'({r_ow, 1'b0});
    assign oh2_a = AW'({r_oh, 1'b0});

    // Restart position on frame start or when a counter falls outside the frame
    assign clr   = i_pix.frame_start || (r_src_col >= r_w) || (r_src_row >= r_h);
    assign c_col = clr ? '0 : r_src_col;
    assign c_row = clr ? '0 : r_src_row;
    assign c_ox  = clr ? '0 : r_out_col;
    assign c_oy  = clr ? '0 : r_out_row;
    assign c_cs  = clr ? '0 : r_cs;
    assign c_ct  = clr ? w_a : r_ct;
    assign c_rs  = clr ? '0 : r_rs;
    assign c_rt  = clr ? h_a : r_rt;

    // Pixel is picked when (2*ox+1)*W lies in [2OW*col, 2OW*col + 2OW), rows alike
    assign row_hit  = (c_oy < r_oh) && (c_rs <= c_rt) && (c_rt < c_rs + oh2_a);
    assign emit     = row_hit && (c_ox < r_ow) && (c_cs <= c_ct) && (c_ct < c_cs + ow2_a);
    assign pos_last = (c_ox == r_ow - DW'(1)) && (c_oy == r_oh - DW'(1));
    assign col_inc  = {1'b0, c_col} + (DW+1)'(1);
    assign row_inc  = {1'b0, c_row} + (DW+1)'(1);

    // Advance counters and running products
    always_comb begin
        n_w = r_w;
        n_h = r_h;
        n_ow = r_ow;
        n_oh = r_oh;
        n_src_col = r_src_col;
        n_src_row = r_src_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_cs = r_cs;
        n_ct = r_ct;
        n_rs = r_rs;
        n_rt = r_rt;
        case (r_rc)
            yds_pkg::RC_DIMS: begin
                n_w  = eff_w;
                n_h  = eff_h;
                n_ow = eff_ow;
                n_oh = eff_oh;
            end
            yds_pkg::RC_COL_S: n_cs = mul_p;
            yds_pkg::RC_COL_T: n_ct = mul_p;
            yds_pkg::RC_ROW_S: n_rs = mul_p;
            yds_pkg::RC_ROW_T: n_rt = mul_p;
            default: begin
                if (pix_acc) begin
                    n_out_col = emit ? c_ox + DW'(1) : c_ox;
                    n_ct      = emit ? c_ct + {w_a[AW-2:0], 1'b0} : c_ct;
                    n_out_row = c_oy;
                    n_rt      = c_rt;
                    n_src_row = c_row;
                    n_rs      = c_rs;
                    n_src_col = col_inc[DW-1:0];
                    n_cs      = c_cs + ow2_a;
                    if (col_inc >= {1'b0, r_w}) begin
                        n_src_col = '0;
                        n_cs      = '0;
                        if (row_hit) begin
                            n_out_row = c_oy + DW'(1);
                            n_rt      = c_rt + {h_a[AW-2:0], 1'b0};
                            n_out_col = '0;
                            n_ct      = w_a;
                        end
                        n_src_row = row_inc[DW-1:0];
                        n_rs      = c_rs + oh2_a;
                        if (row_inc >= {1'b0, r_h}) begin
                            n_src_col = '0;
                            n_src_row = '0;
                            n_out_col = '0;
                            n_out_row = '0;
                            n_cs      = '0;
                            n_ct      = w_a;
                            n_rs      = '0;
                            n_rt      = h_a;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= '0;
            r_h       <= '0;
            r_ow      <= '0;
            r_oh      <= '0;
            r_src_col <= '0;
            r_src_row <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_cs      <= '0;
            r_ct      <= '0;
            r_rs      <= '0;
            r_rt      <= '0;
        end else begin
            r_w       <= n_w;
            r_h       <= n_h;
            r_ow      <= n_ow;
            r_oh      <= n_oh;
            r_src_col <= n_src_col;
            r_src_row <= n_src_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_cs      <= n_cs;
            r_ct      <= n_ct;
            r_rs      <= n_rs;
            r_rt      <= n_rt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: selected pixel and its output position
    // ------------------------------------------------------------------
    logic [SMW-1:0]          r_s1_luma, r_s1_cb, r_s1_cr;
    logic [yds_pkg::POS_W-1:0] r_s1_x, r_s1_y;
    logic                    r_s1_last, r_s1_chroma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s1_valid <= 1'b0;
        else if (pix_acc)
            r_s1_valid <= emit;
        else if (s1_adv)
            r_s1_valid <= 1'b0;
    end

    // Capture the picked pixel
    always_ff @(posedge i_clk) begin
        if (pix_acc && emit) begin
            r_s1_luma   <= i_pix.luma;
            r_s1_cb     <= i_pix.cb_sample;
            r_s1_cr     <= i_pix.cr_sample;
            r_s1_x      <= yds_pkg::POS_W'(c_ox);
            r_s1_y      <= yds_pkg::POS_W'(c_oy);
            r_s1_last   <= pos_last;
            r_s1_chroma <= r_cfg_chroma;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: color conversion into the output register
    // ------------------------------------------------------------------
    logic signed [SMW:0]  cb_d, cr_d;
    logic signed [SW-1:0] ys, acc_r, acc_g, acc_b;
    logic [SMW-1:0]       ch_r, ch_g, ch_b;

    // Clamp to 0..255 in the fixed-point domain, then drop the fraction
    function automatic logic [SMW-1:0] to_channel(input logic signed [SW-1:0] acc);
        if (acc < 0)
            return '0;
        else if (acc > CH_TOP)
            return SMW'(255);
        else
            return acc[F+SMW-1:F];
    endfunction

    always_comb begin
        cb_d  = r_s1_chroma ? $signed({1'b0, r_s1_cb}) - yds_pkg::CHROMA_MID : '0;
        cr_d  = r_s1_chroma ? $signed({1'b0, r_s1_cr}) - yds_pkg::CHROMA_MID : '0;
        ys    = $signed({{(SW-SMW-F){1'b0}}, r_s1_luma, {F{1'b0}}});
        acc_r = ys + SW'(cr_d) * SW'(K_R);
        acc_g = ys - SW'(cb_d) * SW'(K_GB) - SW'(cr_d) * SW'(K_GR);
        acc_b = ys + SW'(cb_d) * SW'(K_B);
        ch_r  = to_channel(acc_r);
        ch_g  = to_channel(acc_g);
        ch_b  = to_channel(acc_b);
    end

    logic r_out_valid, r_out_neutral;
    logic [SMW-1:0] r_out_gray, r_out_red, r_out_green, r_out_blue;
    logic [yds_pkg::POS_W-1:0] r_out_x, r_out_y;
    logic r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (out_free)
            r_out_valid <= r_s1_valid;
    end

    // Load the converted word when the output slot frees up
    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_gray    <= r_s1_luma;
            r_out_red     <= ch_r;
            r_out_green   <= ch_g;
            r_out_blue    <= ch_b;
            r_out_x       <= r_s1_x;
            r_out_y       <= r_s1_y;
            r_out_last    <= r_s1_last;
            r_out_neutral <= !r_s1_chroma;
        end
    end

    assign o_rgb.valid = r_out_valid;
    assign o_rgb.gray  = r_out_gray;
    assign o_rgb.red   = r_out_red;
    assign o_rgb.green = r_out_green;
    assign o_rgb.blue  = r_out_blue;
    assign o_rgb.out_x = r_out_x;
    assign o_rgb.out_y = r_out_y;
    assign o_rgb.last  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !i_pix.ready)
        else $error("pixel input open right after a register write");

    a_neutral_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_neutral) |->
            (r_out_red == r_out_gray && r_out_green == r_out_gray &&
             r_out_blue == r_out_gray))
        else $error("neutral chroma did not give gray RGB");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_x) && $stable(r_s1_y)))
        else $error("stage 1 word changed while output stalled");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_acc && i_pix.frame_start) |=> (r_out_col <= DW'(1) && r_out_row <= DW'(1)))
        else $error("frame start did not restart the output position");

endmodule
